// ----- rtl/ttmec_pkg.sv -----
// Package for the tournament winner tree: field widths, register reset
// value and the sequencer state type. Depends on nothing.
package ttmec_pkg;

   localparam int CFG_W  = 13;
   localparam int CELL_W = 12;
   localparam int HEAD_W = 32;

   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RB_START,
      ST_RB_RD,
      ST_RB_WR,
      ST_IDLE,
      ST_WALK,
      ST_ROOT,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/tournament_tree_min_event_cell_core.sv -----
// An item is accepted in IDLE, then WALK plays one match per tree level, then FINISH loads
// the result register (the node memory read, compare and write are done once per level).
// A cell outside the tree reads the root node instead, through ROOT and then FINISH.
// A new item is taken only in IDLE; a waiting result does not block accepting the next item,
// but that item holds in FINISH until the result is taken. Reset (synchronous, active high):
// a clearing pass fills the leaf memory with empty times, then a rebuild pass over the cells
// in use runs; a csr write after clearing reruns the rebuild. Depends on ttmec_pkg.
module tournament_tree_min_event_cell_core #(
   parameter int CELLS     = 4096,
   parameter int TIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ttmec_pkg::CELL_W-1:0]  req_cell_req,
   input  logic [ttmec_pkg::HEAD_W-1:0]  req_head_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ttmec_pkg::CELL_W-1:0]  rsp_winner_cell,
   output logic [ttmec_pkg::HEAD_W-1:0]  rsp_winner_time,
   input  logic                          csr_we,
   input  logic [ttmec_pkg::CFG_W-1:0]   csr_wdata
);
   import ttmec_pkg::*;

   // Leaf index width, count width (holds CELLS itself) and node memory sizing. The tree
   // has at most CELLS - 1 + levels nodes, since an odd entrant passes up alone.
   localparam int LEAF_AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W      = $clog2(CELLS + 1);
   localparam int NODE_DEPTH = CELLS + LEAF_AW + 2;
   localparam int NODE_AW    = $clog2(NODE_DEPTH);

   // One node entry: winning cell and a copy of its time, so a match needs no leaf lookup.
   typedef struct packed {
      logic [LEAF_AW-1:0]   leaf;
      logic [TIME_BITS-1:0] tval;
   } node_type;

   // Sequencer and datapath registers
   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     csr_ff, csr_in;
   logic [LEAF_AW-1:0]   clr_ff, clr_in;
   logic [LEAF_AW-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]     ent_cnt_ff, ent_cnt_in;
   logic [NODE_AW-1:0]   node_base_ff, node_base_in;
   logic [NODE_AW-1:0]   ent_base_ff, ent_base_in;
   logic [NODE_AW-1:0]   root_ff, root_in;
   logic                 lev0_ff, lev0_in;
   node_type             carry_ff, carry_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;
   logic [HEAD_W-1:0]    rsp_time_ff, rsp_time_in;

   // Memory ports
   logic                 leaf_we;
   logic [LEAF_AW-1:0]   leaf_wa;
   logic [TIME_BITS-1:0] leaf_wd;
   logic [NODE_AW-1:0]   leaf_ra_a_wide, leaf_ra_b_wide;
   logic [LEAF_AW-1:0]   leaf_ra_a, leaf_ra_b;
   logic [TIME_BITS-1:0] leaf_rd_a_ff, leaf_rd_b_ff;
   logic                 node_we;
   logic [NODE_AW-1:0]   node_wa;
   node_type             node_wd;
   logic [NODE_AW-1:0]   node_ra_a, node_ra_b;
   node_type             node_rd_a_ff, node_rd_b_ff;

   // Derived values
   logic [CNT_W-1:0]     n_cells;
   logic [CNT_W:0]       cnt_up;
   logic [CNT_W-1:0]     node_cnt;
   logic [NODE_AW-1:0]   node_cnt_w;
   logic [NODE_AW-1:0]   ent_cnt_w;
   logic [NODE_AW-1:0]   idx_w, idx_p1, half_w, two_i, two_i_p1;
   logic [LEAF_AW-1:0]   req_leaf;
   logic                 req_in_tree;
   logic                 walk_right_ok, rb_right_ok;
   node_type             sib, left_e, right_e, win_e;
   logic                 right_ok;

   // Leaf time store: one write port, two registered read ports
   logic [TIME_BITS-1:0] leaf_mem [CELLS];

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_wa] <= leaf_wd;
      end
      leaf_rd_a_ff <= leaf_mem[leaf_ra_a];
      leaf_rd_b_ff <= leaf_mem[leaf_ra_b];
   end

   // Node winner store: one write port, two registered read ports
   node_type node_mem [NODE_DEPTH];

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_a_ff <= node_mem[node_ra_a];
      node_rd_b_ff <= node_mem[node_ra_b];
   end

   // Saturate the register to the range 2..CELLS; the stored value is kept as written
   always_comb begin
      if (csr_ff < CFG_W'(2)) begin
         n_cells = CNT_W'(2);
      end else if (csr_ff > CELLS) begin
         n_cells = CNT_W'(CELLS);
      end else begin
         n_cells = CNT_W'(csr_ff);
      end
   end

   // Nodes at the level above the current entrants: ceil(entrants / 2)
   assign cnt_up      = {1'b0, ent_cnt_ff} + 1'b1;
   assign node_cnt    = cnt_up[CNT_W:1];
   assign node_cnt_w  = NODE_AW'(node_cnt);
   assign ent_cnt_w   = NODE_AW'(ent_cnt_ff);
   assign idx_w       = NODE_AW'(idx_ff);
   assign idx_p1      = idx_w + 1'b1;
   assign half_w      = NODE_AW'(idx_ff >> 1);
   assign two_i       = idx_w << 1;
   assign two_i_p1    = two_i + 1'b1;
   assign req_leaf    = LEAF_AW'(req_cell_req);
   assign req_in_tree = req_cell_req < n_cells;

   assign walk_right_ok = idx_p1 < ent_cnt_w;
   assign rb_right_ok   = two_i_p1 < ent_cnt_w;

   // Keep leaf reads inside the store when CELLS is not a power of two
   assign leaf_ra_a = (leaf_ra_a_wide < CELLS) ? LEAF_AW'(leaf_ra_a_wide) : '0;
   assign leaf_ra_b = (leaf_ra_b_wide < CELLS) ? LEAF_AW'(leaf_ra_b_wide) : '0;

   // Match selection: the walk carries its own entrant and meets the sibling read last
   // cycle; the rebuild meets the two entrants of one node
   always_comb begin
      sib.leaf = lev0_ff ? (idx_ff ^ LEAF_AW'(1)) : node_rd_a_ff.leaf;
      sib.tval = lev0_ff ? leaf_rd_a_ff : node_rd_a_ff.tval;
      if (state_ff == ST_WALK) begin
         if (!idx_ff[0]) begin
            left_e   = carry_ff;
            right_e  = sib;
            right_ok = walk_right_ok;
         end else begin
            left_e   = sib;
            right_e  = carry_ff;
            right_ok = 1'b1;
         end
      end else begin
         if (lev0_ff) begin
            left_e.leaf  = LEAF_AW'(two_i);
            left_e.tval  = leaf_rd_a_ff;
            right_e.leaf = LEAF_AW'(two_i_p1);
            right_e.tval = leaf_rd_b_ff;
         end else begin
            left_e  = node_rd_a_ff;
            right_e = node_rd_b_ff;
         end
         right_ok = rb_right_ok;
      end
      // Left holds on a tie, so the lower cell index wins
      win_e = (right_ok && (left_e.tval > right_e.tval)) ? right_e : left_e;
   end

   // Sequencer: next state, register updates and memory control
   always_comb begin
      state_in     = state_ff;
      csr_in       = csr_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      ent_cnt_in   = ent_cnt_ff;
      node_base_in = node_base_ff;
      ent_base_in  = ent_base_ff;
      root_in      = root_ff;
      lev0_in      = lev0_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_time_in  = rsp_time_ff;

      leaf_we        = 1'b0;
      leaf_wa        = clr_ff;
      leaf_wd        = '1;
      leaf_ra_a_wide = '0;
      leaf_ra_b_wide = '0;
      node_we        = 1'b0;
      node_wa        = node_base_ff + half_w;
      node_wd        = win_e;
      node_ra_a      = '0;
      node_ra_b      = '0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Fill every leaf with the empty time
            leaf_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LEAF_AW'(CELLS - 1)) begin
               state_in = ST_RB_START;
            end
         end
         ST_RB_START: begin
            ent_cnt_in   = n_cells;
            node_base_in = '0;
            ent_base_in  = '0;
            idx_in       = '0;
            lev0_in      = 1'b1;
            state_in     = ST_RB_RD;
         end
         ST_RB_RD: begin
            leaf_ra_a_wide = two_i;
            leaf_ra_b_wide = two_i_p1;
            node_ra_a      = ent_base_ff + two_i;
            node_ra_b      = ent_base_ff + two_i_p1;
            state_in       = ST_RB_WR;
         end
         ST_RB_WR: begin
            node_we  = 1'b1;
            node_wa  = node_base_ff + idx_w;
            state_in = ST_RB_RD;
            idx_in   = idx_ff + 1'b1;
            if (idx_w == node_cnt_w - 1'b1) begin
               if (node_cnt == CNT_W'(1)) begin
                  root_in  = node_base_ff;
                  state_in = ST_IDLE;
               end else begin
                  // Advance to the next level up
                  ent_base_in  = node_base_ff;
                  node_base_in = node_base_ff + node_cnt_w;
                  ent_cnt_in   = node_cnt;
                  idx_in       = '0;
                  lev0_in      = 1'b0;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_in_tree) begin
                  // Store the leaf and fetch its partner for the first match
                  leaf_we        = 1'b1;
                  leaf_wa        = req_leaf;
                  leaf_wd        = TIME_BITS'(req_head_time);
                  leaf_ra_a_wide = NODE_AW'(req_leaf ^ LEAF_AW'(1));
                  carry_in.leaf  = req_leaf;
                  carry_in.tval  = TIME_BITS'(req_head_time);
                  idx_in         = req_leaf;
                  ent_cnt_in     = n_cells;
                  node_base_in   = '0;
                  lev0_in        = 1'b1;
                  state_in       = ST_WALK;
               end else begin
                  node_ra_a = root_ff;
                  state_in  = ST_ROOT;
               end
            end
         end
         ST_WALK: begin
            // Replay one match and fetch the sibling for the level above
            node_we   = 1'b1;
            carry_in  = win_e;
            node_ra_a = node_base_ff + (half_w ^ NODE_AW'(1));
            if (node_cnt == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in       = idx_ff >> 1;
               ent_cnt_in   = node_cnt;
               node_base_in = node_base_ff + node_cnt_w;
               lev0_in      = 1'b0;
            end
         end
         ST_ROOT: begin
            carry_in = node_rd_a_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = CELL_W'(carry_ff.leaf);
               rsp_time_in  = HEAD_W'(carry_ff.tval);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_RB_START;
         end
      endcase

      // A register write rebuilds all nodes from the stored leaves
      if (csr_we) begin
         csr_in = csr_wdata;
         if (state_ff != ST_CLEAR) begin
            state_in = ST_RB_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         csr_ff       <= CFG_RESET;
         clr_ff       <= '0;
         idx_ff       <= '0;
         ent_cnt_ff   <= '0;
         node_base_ff <= '0;
         ent_base_ff  <= '0;
         root_ff      <= '0;
         lev0_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         ent_cnt_ff   <= ent_cnt_in;
         node_base_ff <= node_base_in;
         ent_base_ff  <= ent_base_in;
         root_ff      <= root_in;
         lev0_ff      <= lev0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff    <= carry_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_winner_cell = rsp_cell_ff;
   assign rsp_winner_time = rsp_time_ff;

   // A new result only comes out of the finishing step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside the finishing step");

   // The walk always has a match left to play
   a_walk_entrants: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (ent_cnt_ff >= CNT_W'(2)))
      else $error("walk running with fewer than two entrants");

   // Rebuild writes follow their read cycle
   a_rb_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RB_WR) |-> $past(state_ff) == ST_RB_RD)
      else $error("rebuild write without its read");

   // Node writes stay inside the node store
   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      node_we |-> (node_wa < NODE_DEPTH))
      else $error("node write beyond the store");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for tournament_tree_min_event_cell_core: a table of directed items,
// then random items under three idling mixes, checked against typed winners or a winner-search predictor.
// Depends on ttmec_pkg and the core RTL.
module tb;
   import ttmec_pkg::*;

   localparam int CLK_PERIOD = 8;
   localparam int MAX_CELLS  = 4096;
   localparam int BLOCKS     = 15;
   localparam int BLOCK_ITEMS = 50;

   typedef struct {
      logic [CELL_W-1:0] cell_id;
      logic [HEAD_W-1:0] when;
   } winner_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [CELL_W-1:0] cell_id;
      logic [HEAD_W-1:0] value;
      bit                typed;
      logic [CELL_W-1:0] want_cell;
      logic [HEAD_W-1:0] want_when;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CELL_W-1:0] req_cell_req = '0;
   logic [HEAD_W-1:0] req_head_time = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CELL_W-1:0] rsp_winner_cell;
   logic [HEAD_W-1:0] rsp_winner_time;
   logic              csr_we = 1'b0;
   logic [CFG_W-1:0]  csr_wdata = '0;

   // Predictor state: leaf times and the effective number of cells in the tree.
   logic [HEAD_W-1:0] cell_time [MAX_CELLS];
   int unsigned       live_cells = MAX_CELLS;

   winner_type   pending_winners[$];
   plan_row_type plan[$];
   int           failures = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;

   tournament_tree_min_event_cell_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_req    (req_cell_req),
      .req_head_time   (req_head_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_winner_cell (rsp_winner_cell),
      .rsp_winner_time (rsp_winner_time),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD/2) clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run (clearing, rebuilds, stalls included).
   initial begin
      #(CLK_PERIOD * 1_500_000);
      $display("FAIL tournament_tree_min_event_cell_core");
      $finish;
   end

   // The tree always settles on the smallest time with the lowest index among ties, so a
   // straight scan of the live leaves gives the root winner.
   function automatic winner_type find_earliest_cell();
      winner_type best;
      best.cell_id = '0;
      best.when    = cell_time[0];
      for (int unsigned i = 1; i < live_cells; i++) begin
         if (cell_time[i] < best.when) begin
            best.cell_id = i[CELL_W-1:0];
            best.when    = cell_time[i];
         end
      end
      return best;
   endfunction

   task automatic flag(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // Present one item, hold it until accepted, then update the leaf and queue the winner.
   task automatic send_item(input logic [CELL_W-1:0] cell_id, input logic [HEAD_W-1:0] head,
                            input bit typed = 1'b0,
                            input winner_type typed_winner = '{0, 0});
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_req  <= cell_id;
      req_head_time <= head;
      do @(posedge clock); while (!req_ready);
      // Cells beyond the live count leave the leaves untouched.
      if (cell_id < live_cells) cell_time[cell_id] = head;
      pending_winners.push_back(typed ? typed_winner : find_earliest_cell());
   endtask

   // Drop valid and hold off until every expected winner has come back, plus the walk time.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_winners.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_cells_in_use(input logic [CFG_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      // Saturate to the range the tree can hold; leaf times survive the rebuild.
      if (value < 2) live_cells = 2;
      else if (value > MAX_CELLS) live_cells = MAX_CELLS;
      else live_cells = value;
   endtask

   // Receiver: stall at random each cycle according to the current mix.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Compare every accepted result with the oldest expectation, field by field.
   always @(posedge clock) begin : watch_results
      winner_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_winners.size() == 0) begin
            flag($sformatf("unexpected item: cell %0d time %h",
                           rsp_winner_cell, rsp_winner_time));
         end else begin
            want = pending_winners.pop_front();
            if (rsp_winner_cell !== want.cell_id)
               flag($sformatf("winner_cell: expected %0d, got %0d", want.cell_id,
                              rsp_winner_cell));
            if (rsp_winner_time !== want.when)
               flag($sformatf("winner_time: expected %h, got %h", want.when,
                              rsp_winner_time));
         end
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0]  cfg_sweep[$];
      logic [CELL_W-1:0] cell_id;
      logic [HEAD_W-1:0] head;
      plan_row_type      row;
      for (int i = 0; i < MAX_CELLS; i++) cell_time[i] = '1;

      // Directed plan. Typed winners are those readable at a glance; zeros mean predicted.
      plan.push_back('{ROW_ITEM, 12'd7,    32'hFFFF_FFFF, 1, 12'd0,    32'hFFFF_FFFF});
      plan.push_back('{ROW_ITEM, 12'd4095, 32'h0000_0000, 1, 12'd4095, 32'h0000_0000});
      plan.push_back('{ROW_ITEM, 12'd0,    32'h0000_0000, 1, 12'd0,    32'h0000_0000});
      plan.push_back('{ROW_ITEM, 12'd0,    32'hFFFF_FFFF, 1, 12'd4095, 32'h0000_0000});
      plan.push_back('{ROW_ITEM, 12'd2048, 32'h0000_0000, 1, 12'd2048, 32'h0000_0000});
      plan.push_back('{ROW_ITEM, 12'd1,    32'hAAAA_5555, 0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd2,    32'h5555_AAAA, 0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd4095, 32'hFFFF_FFFF, 0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd2048, 32'hFFFF_FFFF, 0, 12'd0,    32'h0});
      // Count below range saturates to two: cells 2 and 4095 fall outside the tree.
      plan.push_back('{ROW_CFG,  12'd0,    32'd0,         0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd2,    32'h0000_0000, 1, 12'd1,    32'hAAAA_5555});
      plan.push_back('{ROW_ITEM, 12'd4095, 32'h0000_0000, 1, 12'd1,    32'hAAAA_5555});
      plan.push_back('{ROW_ITEM, 12'd0,    32'h1234_5678, 1, 12'd0,    32'h1234_5678});
      // Count above range saturates to the full tree; stored leaves come back in.
      plan.push_back('{ROW_CFG,  12'd0,    32'd8191,      0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd3000, 32'h0000_0000, 1, 12'd3000, 32'h0000_0000});
      plan.push_back('{ROW_CFG,  12'd0,    32'd1,         0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd1,    32'h0000_0000, 1, 12'd1,    32'h0000_0000});
      // Three cells: the odd entrant passes up alone, ties still go to the lower cell.
      plan.push_back('{ROW_CFG,  12'd0,    32'd3,         0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd2,    32'h0000_0000, 1, 12'd1,    32'h0000_0000});
      plan.push_back('{ROW_ITEM, 12'd1,    32'hFFFF_FFFF, 1, 12'd2,    32'h0000_0000});
      plan.push_back('{ROW_CFG,  12'd0,    32'd4096,      0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd3000, 32'hFFFF_FFFF, 1, 12'd2,    32'h0000_0000});
      plan.push_back('{ROW_ITEM, 12'd2,    32'h7FFF_FFFF, 0, 12'd0,    32'h0});
      plan.push_back('{ROW_ITEM, 12'd4094, 32'h0000_0001, 0, 12'd0,    32'h0});

      cfg_sweep = '{13'd2, 13'd4096, 13'd3, 13'd0, 13'd8191, 13'd1, 13'd5, 13'd4095,
                    13'd4097, 13'd17, 13'd2048, 13'd100};

      // Hold reset, then release it at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed plan with idling on both sides, sender at 31 and receiver at 61 percent.
      send_idle_pct = 31;
      recv_idle_pct = 61;
      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CFG)
            write_cells_in_use(row.value[CFG_W-1:0]);
         else
            send_item(row.cell_id, row.value, row.typed, '{row.want_cell, row.want_when});
      end

      // Random part: each block starts with a new cell count, idling mix by thirds.
      for (int blk = 0; blk < BLOCKS; blk++) begin
         case (blk / 5)
            0: begin send_idle_pct = 31; recv_idle_pct = 61; end
            1: begin send_idle_pct = 61; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_cells_in_use(blk < cfg_sweep.size() ? cfg_sweep[blk]
                                                   : CFG_W'($urandom_range(0, 8191)));
         for (int k = 0; k < BLOCK_ITEMS; k++) begin
            // Once, hold the sender until the block has drained completely.
            if (blk == 7 && k == 25) wait_idle();
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: cell_id = CELL_W'($urandom_range(0, live_cells - 1));
               7, 8:                cell_id = CELL_W'($urandom_range(0, 7));
               default:             cell_id = CELL_W'($urandom);
            endcase
            // Favour corner and tiny times so that ties and empties turn up often.
            case ($urandom_range(0, 7))
               0, 1: begin
                  case ($urandom_range(0, 3))
                     0:       head = '0;
                     1:       head = '1;
                     2:       head = 32'h8000_0000;
                     default: head = 32'h0001_0000;
                  endcase
               end
               2, 3:    head = HEAD_W'($urandom_range(0, 15));
               default: head = $urandom;
            endcase
            send_item(cell_id, head);
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (failures == 0 && pending_winners.size() == 0) begin
         $display("PASS tournament_tree_min_event_cell_core");
      end else begin
         $display("FAIL tournament_tree_min_event_cell_core");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ttmec_pkg.sv
rtl/tournament_tree_min_event_cell_core.sv
test/tb.sv
